>>> rtl/point_affine_transform_core_defines.svh
// ----------------------------------------------------------------------------
// Point affine transform core - assertion macros
// Shared concurrent assertion forms for the transform core.
// ----------------------------------------------------------------------------
`ifndef POINT_AFFINE_TRANSFORM_CORE_DEFINES_SVH
`define POINT_AFFINE_TRANSFORM_CORE_DEFINES_SVH

// check a consequence in the same cycle
`define PAT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("point transform assertion failed");

// check a consequence in the following cycle
`define PAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("point transform assertion failed");

`endif

>>> rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Constants, types and arithmetic helpers of the point affine transform core.
// ----------------------------------------------------------------------------
package pat_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int TRIG_STEPS  = 16;
   localparam int TRIG_FRAC   = 16;

   localparam int CW     = COORD_WIDTH;
   localparam int DW     = CW + 1;
   localparam int TW     = 18;
   localparam int PW_S   = CW + DW;
   localparam int PW_T   = DW + TW;
   localparam int SUM_W  = PW_S - FRAC_BITS + 2;
   localparam int ANG_W  = 34;
   localparam int XY_W   = 34;
   localparam int STEP_W = $clog2(TRIG_STEPS);

   localparam int PIPE_DEPTH = 10;
   localparam int LIN_DELAY  = 6;

   localparam logic signed [ANG_W-1:0] ANG_FULL    = ANG_W'(360 * 65536);
   localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(180 * 65536);
   localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(90 * 65536);
   localparam logic signed [XY_W-1:0]  CORDIC_K    = XY_W'(652032874);

   localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   typedef logic signed [CW-1:0]  coord_type;
   typedef logic signed [DW-1:0]  diff_type;
   typedef logic signed [TW-1:0]  trig_val_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   typedef enum logic [2:0] {
      REG_MODE     = 3'd0,
      REG_CENTER_X = 3'd1,
      REG_CENTER_Y = 3'd2,
      REG_CENTER_Z = 3'd3,
      REG_PARAM_X  = 3'd4,
      REG_PARAM_Y  = 3'd5,
      REG_PARAM_Z  = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_TRANSLATE = 2'd0,
      MODE_SCALE     = 2'd1,
      MODE_ROTATE    = 2'd2
   } mode_type;

   typedef struct packed {
      trig_val_type sin_x;
      trig_val_type cos_x;
      trig_val_type sin_y;
      trig_val_type cos_y;
      trig_val_type sin_z;
      trig_val_type cos_z;
   } trig_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      hit;
   } point_type;

   function automatic logic [21:0] atan_deg(input logic [4:0] idx);
      logic [21:0] r;
      case (idx)
         5'd0:  r = 22'd2949120;
         5'd1:  r = 22'd1740967;
         5'd2:  r = 22'd919879;
         5'd3:  r = 22'd466945;
         5'd4:  r = 22'd234379;
         5'd5:  r = 22'd117304;
         5'd6:  r = 22'd58666;
         5'd7:  r = 22'd29335;
         5'd8:  r = 22'd14668;
         5'd9:  r = 22'd7334;
         5'd10: r = 22'd3667;
         5'd11: r = 22'd1833;
         5'd12: r = 22'd917;
         5'd13: r = 22'd458;
         5'd14: r = 22'd229;
         5'd15: r = 22'd115;
         5'd16: r = 22'd57;
         5'd17: r = 22'd29;
         5'd18: r = 22'd14;
         5'd19: r = 22'd7;
         5'd20: r = 22'd4;
         5'd21: r = 22'd2;
         5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   // round to nearest, ties away from zero, then drop sh fraction bits
   function automatic logic signed [PW_S-1:0] round_prod(input logic signed [PW_S-1:0] p,
                                                         input int sh);
      logic signed [PW_S-1:0] bias;
      bias = (PW_S'(1) <<< (sh - 1)) - PW_S'(p[PW_S-1]);
      return (p + bias) >>> sh;
   endfunction

   function automatic coord_type sat_coord(input sum_type v);
      coord_type r;
      if (v > SAT_HI) r = SAT_HI[CW-1:0];
      else if (v < SAT_LO) r = SAT_LO[CW-1:0];
      else r = v[CW-1:0];
      return r;
   endfunction

   function automatic logic sat_hit(input sum_type v);
      return (v > SAT_HI) || (v < SAT_LO);
   endfunction

endpackage

>>> rtl/point_affine_transform_core.sv
// ----------------------------------------------------------------------------
// point_affine_transform_core
// Translates, scales or rotates one Q16.16 3D point per word, saturating.
//
//   channel  direction  content
//   req_*    in         point word: x, y, z
//   rsp_*    out        point word: x, y, z; tuser = saturated
//   csr_*    in         register index and write data
//
// One point per cycle while rsp is not stalled and no angle write runs; the rotation
// path is three rotation units of three stages each plus the output register.
// A write of an angle register runs the CORDIC unit (seven reduction steps, two folds,
// sixteen iterations, one store); meanwhile req_tready and csr_ready stay low.
// Reset clears the control and valid registers, the CORDIC state and the sine/cosine cache.
// A stall on rsp holds every pipeline stage in place.
// ----------------------------------------------------------------------------
`include "point_affine_transform_core_defines.svh"

module point_affine_transform_core
   import pat_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,    // in_x, in_y, in_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,    // out_x, out_y, out_z
   output logic         rsp_tuser,    // saturated
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic [1:0] mode_ff;
   coord_type  cx_ff, cy_ff, cz_ff, px_ff, py_ff, pz_ff;
   logic       csr_wr, trig_busy, trig_start, adv, req_acc;
   trig_type   trig;
   logic [PIPE_DEPTH-1:0] vld_ff;
   coord_type  in_x, in_y, in_z;
   coord_type  lx, ly, lz;
   logic       lhx, lhy, lhz;
   point_type  lin_dly_ff [0:LIN_DELAY-1];
   coord_type  ax_y, ax_z, ax_x;
   logic       ax_h;
   coord_type  ay_x, ay_z, ay_y;
   logic       ay_h;
   coord_type  az_x, az_y, az_z;
   logic       az_h;
   point_type  out_in, out_ff;

   assign in_x = req_tdata[CW-1:0];
   assign in_y = req_tdata[2*CW-1:CW];
   assign in_z = req_tdata[3*CW-1:2*CW];

   assign adv        = !vld_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = adv && !trig_busy;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = !trig_busy;
   assign csr_wr     = csr_valid && csr_ready;
   assign trig_start = csr_wr && (csr_index >= REG_PARAM_X) && (csr_index <= REG_PARAM_Z);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         cx_ff   <= '0;
         cy_ff   <= '0;
         cz_ff   <= '0;
         px_ff   <= '0;
         py_ff   <= '0;
         pz_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_MODE:     mode_ff <= csr_data[1:0];
            REG_CENTER_X: cx_ff   <= csr_data;
            REG_CENTER_Y: cy_ff   <= csr_data;
            REG_CENTER_Z: cz_ff   <= csr_data;
            REG_PARAM_X:  px_ff   <= csr_data;
            REG_PARAM_Y:  py_ff   <= csr_data;
            REG_PARAM_Z:  pz_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   pat_trig u_trig (
      .clock (clock),
      .reset (reset),
      .start (trig_start),
      .axis  (2'(csr_index - REG_PARAM_X)),
      .angle (csr_data),
      .busy  (trig_busy),
      .cache (trig)
   );

   pat_lin u_lin_x (.clock(clock), .adv(adv), .mode(mode_ff), .p(in_x), .c(cx_ff),
                    .param(px_ff), .q(lx), .hit(lhx));
   pat_lin u_lin_y (.clock(clock), .adv(adv), .mode(mode_ff), .p(in_y), .c(cy_ff),
                    .param(py_ff), .q(ly), .hit(lhy));
   pat_lin u_lin_z (.clock(clock), .adv(adv), .mode(mode_ff), .p(in_z), .c(cz_ff),
                    .param(pz_ff), .q(lz), .hit(lhz));

   pat_turn u_turn_x (
      .clock(clock), .adv(adv), .u(in_y), .v(in_z), .w(in_x), .hit_i(1'b0),
      .cu(cy_ff), .cv(cz_ff), .sn(trig.sin_x), .cs(trig.cos_x),
      .u_o(ax_y), .v_o(ax_z), .w_o(ax_x), .hit_o(ax_h)
   );

   pat_turn u_turn_y (
      .clock(clock), .adv(adv), .u(ax_x), .v(ax_z), .w(ax_y), .hit_i(ax_h),
      .cu(cx_ff), .cv(cz_ff), .sn(trig.sin_y), .cs(trig.cos_y),
      .u_o(ay_x), .v_o(ay_z), .w_o(ay_y), .hit_o(ay_h)
   );

   pat_turn u_turn_z (
      .clock(clock), .adv(adv), .u(ay_x), .v(ay_y), .w(ay_z), .hit_i(ay_h),
      .cu(cx_ff), .cv(cy_ff), .sn(trig.sin_z), .cs(trig.cos_z),
      .u_o(az_x), .v_o(az_y), .w_o(az_z), .hit_o(az_h)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_dly_ff[0] <= '{x: lx, y: ly, z: lz, hit: lhx | lhy | lhz};
         for (int n = 1; n < LIN_DELAY; n++) lin_dly_ff[n] <= lin_dly_ff[n-1];
         out_ff <= out_in;
      end
   end

   always_comb begin
      if (mode_ff == MODE_ROTATE) out_in = '{x: az_x, y: az_y, z: az_z, hit: az_h};
      else out_in = lin_dly_ff[LIN_DELAY-1];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_acc};
   end

   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {out_ff.z, out_ff.y, out_ff.x};
   assign rsp_tuser  = out_ff.hit;

   `PAT_ASSERT_NOW(a_busy_blocks_req, clock, reset, trig_busy, !req_tready && !csr_ready)
   `PAT_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, rsp_tvalid && !rsp_tready, $stable(vld_ff))
   `PAT_ASSERT_NEXT(a_angle_write_starts, clock, reset, trig_start, trig_busy)
   `PAT_ASSERT_NEXT(a_accept_enters, clock, reset, req_acc, vld_ff[0])

endmodule

>>> rtl/pat_trig.sv
// ----------------------------------------------------------------------------
// pat_trig
// Sequential CORDIC unit: reduces an angle register and stores its sine and
// cosine in the cache.
// ----------------------------------------------------------------------------
module pat_trig
   import pat_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic [1:0] axis,
   input  coord_type angle,
   output logic      busy,
   output trig_type  cache
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_REDUCE = 6'b000010,
      ST_HALF   = 6'b000100,
      ST_QUAD   = 6'b001000,
      ST_ITER   = 6'b010000,
      ST_STORE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [2:0]        k_ff, k_in;
   logic [STEP_W-1:0] i_ff, i_in;
   logic              neg_ff, neg_in;
   logic [1:0]        axis_ff, axis_in;
   trig_val_type      cache_ff [0:5];
   logic signed [XY_W-1:0] xs, ys, xr, yr;
   logic signed [ANG_W-1:0] ang_ext, wrap, step_ang;
   trig_val_type      sin_v, cos_v;

   assign ang_ext  = ANG_W'(angle);
   assign wrap     = ANG_FULL <<< k_ff;
   assign xs       = x_ff >>> i_ff;
   assign ys       = y_ff >>> i_ff;
   assign step_ang = ANG_W'(atan_deg(5'(i_ff)));
   assign xr       = (x_ff + XY_W'(1 << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
   assign yr       = (y_ff + XY_W'(1 << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
   assign cos_v    = neg_ff ? -xr[TW-1:0] : xr[TW-1:0];
   assign sin_v    = neg_ff ? -yr[TW-1:0] : yr[TW-1:0];

   always_comb begin
      state_in = state_ff;
      ang_in   = ang_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      neg_in   = neg_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ang_in   = angle[CW-1] ? ang_ext + (ANG_FULL <<< 7) : ang_ext;
               axis_in  = axis;
               k_in     = 3'd6;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (ang_ff >= wrap) ang_in = ang_ff - wrap;
            if (k_ff == 3'd0) state_in = ST_HALF;
            else k_in = k_ff - 3'd1;
         end
         ST_HALF: begin
            if (ang_ff > ANG_HALF) ang_in = ang_ff - ANG_FULL;
            state_in = ST_QUAD;
         end
         ST_QUAD: begin
            neg_in = 1'b0;
            if (ang_ff > ANG_QUARTER) begin
               ang_in = ang_ff - ANG_HALF;
               neg_in = 1'b1;
            end else if (ang_ff < -ANG_QUARTER) begin
               ang_in = ang_ff + ANG_HALF;
               neg_in = 1'b1;
            end
            x_in     = CORDIC_K;
            y_in     = '0;
            i_in     = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (!ang_ff[ANG_W-1]) begin
               x_in   = x_ff - ys;
               y_in   = y_ff + xs;
               ang_in = ang_ff - step_ang;
            end else begin
               x_in   = x_ff + ys;
               y_in   = y_ff - xs;
               ang_in = ang_ff + step_ang;
            end
            if (i_ff == STEP_W'(TRIG_STEPS - 1)) state_in = ST_STORE;
            else i_in = i_ff + STEP_W'(1);
         end
         ST_STORE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int n = 0; n < 6; n++) cache_ff[n] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_STORE) begin
            cache_ff[{axis_ff, 1'b0}] <= sin_v;
            cache_ff[{axis_ff, 1'b1}] <= cos_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      ang_ff  <= ang_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      neg_ff  <= neg_in;
      axis_ff <= axis_in;
   end

   assign busy  = (state_ff != ST_IDLE);
   assign cache = '{sin_x: cache_ff[0], cos_x: cache_ff[1],
                    sin_y: cache_ff[2], cos_y: cache_ff[3],
                    sin_z: cache_ff[4], cos_z: cache_ff[5]};

endmodule

>>> rtl/pat_lin.sv
// ----------------------------------------------------------------------------
// pat_lin
// Three-stage translate / scale datapath for one axis.
// ----------------------------------------------------------------------------
module pat_lin
   import pat_pkg::*;
(
   input  logic       clock,
   input  logic       adv,
   input  logic [1:0] mode,
   input  coord_type  p,
   input  coord_type  c,
   input  coord_type  param,
   output coord_type  q,
   output logic       hit
);

   diff_type               d1_ff, d1_in;
   coord_type              tr1_ff, tr2_ff, p1_ff, p2_ff;
   logic                   th1_ff, th2_ff;
   logic signed [PW_S-1:0] prod2_ff, prod2_in;
   sum_type                tsum, ssum, res;
   coord_type              q_ff, q_in;
   logic                   hit_ff, hit_in;

   assign d1_in    = DW'(p) - DW'(c);
   assign tsum     = SUM_W'(p) + SUM_W'(param);
   assign prod2_in = PW_S'(param) * PW_S'(d1_ff);
   assign ssum     = SUM_W'(c) + SUM_W'(round_prod(prod2_ff, FRAC_BITS));

   always_comb begin
      q_in   = p2_ff;
      hit_in = 1'b0;
      res    = ssum;
      case (mode)
         MODE_TRANSLATE: begin
            q_in   = tr2_ff;
            hit_in = th2_ff;
         end
         MODE_SCALE: begin
            q_in   = sat_coord(res);
            hit_in = sat_hit(res);
         end
         default: begin
            q_in   = p2_ff;
            hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff    <= d1_in;
         tr1_ff   <= sat_coord(tsum);
         th1_ff   <= sat_hit(tsum);
         p1_ff    <= p;
         prod2_ff <= prod2_in;
         tr2_ff   <= tr1_ff;
         th2_ff   <= th1_ff;
         p2_ff    <= p1_ff;
         q_ff     <= q_in;
         hit_ff   <= hit_in;
      end
   end

   assign q   = q_ff;
   assign hit = hit_ff;

endmodule

>>> rtl/pat_turn.sv
// ----------------------------------------------------------------------------
// pat_turn
// Three-stage rotation of one coordinate pair about a centre.
// ----------------------------------------------------------------------------
module pat_turn
   import pat_pkg::*;
(
   input  logic         clock,
   input  logic         adv,
   input  coord_type    u,
   input  coord_type    v,
   input  coord_type    w,
   input  logic         hit_i,
   input  coord_type    cu,
   input  coord_type    cv,
   input  trig_val_type sn,
   input  trig_val_type cs,
   output coord_type    u_o,
   output coord_type    v_o,
   output coord_type    w_o,
   output logic         hit_o
);

   diff_type               du_ff, dv_ff;
   coord_type              w1_ff, w2_ff, w3_ff;
   logic                   h1_ff, h2_ff, h3_ff;
   logic signed [PW_T-1:0] uc_ff, vs_ff, us_ff, vc_ff;
   sum_type                nu, nv;
   coord_type              u3_ff, v3_ff;

   assign nu = SUM_W'(cu) + SUM_W'(round_prod(PW_S'(uc_ff), TRIG_FRAC))
             - SUM_W'(round_prod(PW_S'(vs_ff), TRIG_FRAC));
   assign nv = SUM_W'(cv) + SUM_W'(round_prod(PW_S'(us_ff), TRIG_FRAC))
             + SUM_W'(round_prod(PW_S'(vc_ff), TRIG_FRAC));

   always_ff @(posedge clock) begin
      if (adv) begin
         du_ff <= DW'(u) - DW'(cu);
         dv_ff <= DW'(v) - DW'(cv);
         w1_ff <= w;
         h1_ff <= hit_i;
         uc_ff <= PW_T'(du_ff) * PW_T'(cs);
         vs_ff <= PW_T'(dv_ff) * PW_T'(sn);
         us_ff <= PW_T'(du_ff) * PW_T'(sn);
         vc_ff <= PW_T'(dv_ff) * PW_T'(cs);
         w2_ff <= w1_ff;
         h2_ff <= h1_ff;
         u3_ff <= sat_coord(nu);
         v3_ff <= sat_coord(nv);
         w3_ff <= w2_ff;
         h3_ff <= h2_ff | sat_hit(nu) | sat_hit(nv);
      end
   end

   assign u_o   = u3_ff;
   assign v_o   = v3_ff;
   assign w_o   = w3_ff;
   assign hit_o = h3_ff;

endmodule
